/* sv/lcs_pkg.sv */
// shared types, codes and constants of the least-connections selector
`timescale 1ns / 1ps
`default_nettype none

package lcs_pkg;

  // default sizes
  localparam int unsigned MaxServersDef = 4;
  localparam int unsigned CountWidthDef = 16;

  // fixed field widths
  localparam int unsigned IdxW     = 2;
  localparam int unsigned PortW    = 16;
  localparam int unsigned ReqW     = 3;
  localparam int unsigned ServCntW = 3;
  localparam int unsigned PortsW   = 64;
  localparam int unsigned OutCntW  = 16;

  // request kinds
  typedef enum logic [ReqW-1:0] {
    REQ_PLUS   = 3'd0,
    REQ_MINUS  = 3'd1,
    REQ_HEALTH = 3'd2,
    REQ_PICK   = 3'd3,
    REQ_QUERY  = 3'd4
  } req_e;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NO_MATCH  = 2'd1,
    STAT_NO_ALIVE  = 2'd2,
    STAT_BAD_INDEX = 2'd3
  } status_e;

  // configuration register indexes
  typedef enum logic {
    REG_SERVER_PORTS = 1'b0,
    REG_SERVER_COUNT = 1'b1
  } cfg_reg_e;

  // sequencer to scan unit
  typedef struct packed {
    logic start;
    logic step;
    logic pick;
  } scan_ctrl_t;

  // scan unit to sequencer
  typedef struct packed {
    logic            found;
    logic [IdxW-1:0] best;
  } scan_res_t;

endpackage

`default_nettype wire

/* sv/lcs_scan.sv */
// shared compare unit that walks the server table one entry per cycle while step is set
`timescale 1ns / 1ps
`default_nettype none

module lcs_scan
  import lcs_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = CountWidthDef
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire scan_ctrl_t             ctrl_i,
  input  wire logic [IdxW-1:0]        entry_idx_i,
  input  wire logic [PortW-1:0]       entry_port_i,
  input  wire logic                   entry_alive_i,
  input  wire logic [COUNT_WIDTH-1:0] entry_count_i,
  input  wire logic [PortW-1:0]       target_port_i,
  output scan_res_t                   res_o
);

  logic                   found_q, found_d;
  logic [IdxW-1:0]        best_q, best_d;
  logic [COUNT_WIDTH-1:0] best_cnt_q, best_cnt_d;
  logic                   take;

  // pick: fewest connections among alive, first wins ties
  // match: last matching port wins
  always_comb begin
    if (ctrl_i.pick) begin
      take = entry_alive_i && (!found_q || (entry_count_i < best_cnt_q));
    end else begin
      take = (entry_port_i == target_port_i);
    end
  end

  always_comb begin
    found_d    = found_q;
    best_d     = best_q;
    best_cnt_d = best_cnt_q;
    if (ctrl_i.start) begin
      found_d = 1'b0;
      best_d  = '0;
    end else if (ctrl_i.step && take) begin
      found_d    = 1'b1;
      best_d     = entry_idx_i;
      best_cnt_d = entry_count_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      best_q  <= '0;
    end else begin
      found_q <= found_d;
      best_q  <= best_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_cnt_q <= best_cnt_d;
  end

  assign res_o.found = found_q;
  assign res_o.best  = best_q;

endmodule

`default_nettype wire

/* sv/least_connections_selector.sv */
// top level: server table, request sequencer and result register
//
// least-connections server selector
// - config port: cfg_we_i writes cfg_wdata_i to register cfg_addr_i at a rising
//   edge (0 server ports, four 16-bit ports packed; 1 servers in use);
//   write only while the block is idle
// - request beats arrive on the s_axis group, tuser carries the request kind,
//   tdata the requesting port, server index and health flag
// - each request gives exactly one result beat on the m_axis group,
//   tuser carrying the status and tdata the server index, alive flag and count
// - plus, minus and pick walk the servers in use one per cycle through the
//   shared compare unit, health reports and queries skip the walk; each
//   request then passes the exec and result steps before the sequencer
//   returns to idle and takes the next request
// - the next request is taken once the result has gone into the output
//   register, so a waiting result does not block the following accept
// - if the receiver stalls, the result holds in the output register and the
//   sequencer waits in its final step until the register frees up
// - reset clears the control registers, alive flags and counts at once; no sweep

`timescale 1ns / 1ps
`default_nettype none

module least_connections_selector
  import lcs_pkg::*;
#(
  parameter int unsigned MAX_SERVERS = MaxServersDef,
  parameter int unsigned COUNT_WIDTH = CountWidthDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // configuration writes
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_addr_i,
  input  wire logic [PortsW-1:0] cfg_wdata_i,
  // request stream
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [23:0]       s_axis_tdata,  // req_port, server_index, alive, pad
  input  wire logic [ReqW-1:0]   s_axis_tuser,  // req_type
  // result stream
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [23:0]            m_axis_tdata,  // chosen_index, on_duty, conn_count, pad
  output logic [1:0]             m_axis_tuser   // status
);

  localparam int unsigned TblIdxW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam logic [ServCntW-1:0] MaxN = ServCntW'(MAX_SERVERS);

  // one-hot sequencer
  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_EXEC   = 4'b0100,
    S_RESULT = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [PortsW-1:0]   ports_q;
  logic [ServCntW-1:0] serv_cnt_q;
  logic [ServCntW-1:0] n_use;

  // server table
  logic                   alive_q [MAX_SERVERS];
  logic [COUNT_WIDTH-1:0] count_q [MAX_SERVERS];

  // latched request
  logic [ReqW-1:0]  req_q;
  logic [PortW-1:0] port_q;
  logic [IdxW-1:0]  idx_q;
  logic             up_q;

  logic [ServCntW-1:0] scan_cnt_q, scan_cnt_d;

  // result of the exec step
  status_e         res_status_q, res_status_d;
  logic            res_zero_q, res_zero_d;
  logic [IdxW-1:0] res_idx_q, res_idx_d;

  // output register
  logic               out_valid_q;
  status_e            out_status_q;
  logic [IdxW-1:0]    out_idx_q;
  logic               out_duty_q;
  logic [OutCntW-1:0] out_count_q;

  logic in_beat, out_free, is_scan_req, idx_ok;
  logic [IdxW-1:0]     scan_idx;
  logic [TblIdxW-1:0]  ent_tbl, upd_tbl, res_tbl;
  scan_ctrl_t          scan_ctrl;
  scan_res_t           scan_res;
  logic [COUNT_WIDTH-1:0] upd_count;
  logic                   upd_we;
  logic                   upd_alive;

  // servers in use, oversized settings saturate
  assign n_use = (serv_cnt_q > MaxN) ? MaxN : serv_cnt_q;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  always_comb begin
    case (s_axis_tuser) inside
      REQ_PLUS, REQ_MINUS, REQ_PICK: is_scan_req = 1'b1;
      default:                       is_scan_req = 1'b0;
    endcase
  end

  // entry under the scan unit
  assign scan_idx = scan_cnt_q[IdxW-1:0];
  assign ent_tbl  = scan_idx[TblIdxW-1:0];

  assign scan_ctrl.start = in_beat;
  assign scan_ctrl.step  = (state_q == S_SCAN);
  assign scan_ctrl.pick  = (req_q == REQ_PICK);

  lcs_scan #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (scan_ctrl),
    .entry_idx_i   (scan_idx),
    .entry_port_i  (ports_q[PortW*scan_idx +: PortW]),
    .entry_alive_i (alive_q[ent_tbl]),
    .entry_count_i (count_q[ent_tbl]),
    .target_port_i (port_q),
    .res_o         (scan_res)
  );

  // sequencer
  always_comb begin
    state_d    = state_q;
    scan_cnt_d = scan_cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          scan_cnt_d = '0;
          state_d    = (is_scan_req && (n_use != '0)) ? S_SCAN : S_EXEC;
        end
      end
      S_SCAN: begin
        if (scan_cnt_q == n_use - ServCntW'(1)) begin
          state_d = S_EXEC;
        end else begin
          scan_cnt_d = scan_cnt_q + ServCntW'(1);
        end
      end
      S_EXEC: begin
        state_d = S_RESULT;
      end
      S_RESULT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // decide status and table update
  assign idx_ok = ({1'b0, idx_q} < n_use);

  always_comb begin
    res_status_d = STAT_OK;
    res_zero_d   = 1'b0;
    res_idx_d    = '0;
    upd_we       = 1'b0;
    upd_alive    = 1'b0;
    upd_count    = '0;
    upd_tbl      = scan_res.best[TblIdxW-1:0];
    unique case (req_q) inside
      REQ_PLUS, REQ_MINUS: begin
        upd_alive = alive_q[upd_tbl];
        if (scan_res.found) begin
          res_idx_d = scan_res.best;
          upd_we    = 1'b1;
          upd_count = count_q[upd_tbl];
          if (req_q == REQ_PLUS) begin
            if (count_q[upd_tbl] != {COUNT_WIDTH{1'b1}}) begin
              upd_count = count_q[upd_tbl] + COUNT_WIDTH'(1);
            end
          end else if (count_q[upd_tbl] != '0) begin
            upd_count = count_q[upd_tbl] - COUNT_WIDTH'(1);
          end
        end else begin
          res_status_d = STAT_NO_MATCH;
        end
      end
      REQ_HEALTH: begin
        upd_tbl   = idx_q[TblIdxW-1:0];
        upd_alive = up_q;
        upd_count = up_q ? count_q[upd_tbl] : '0;
        if (idx_ok) begin
          res_idx_d = idx_q;
          upd_we    = 1'b1;
        end else begin
          res_status_d = STAT_BAD_INDEX;
        end
      end
      REQ_PICK: begin
        if (scan_res.found) begin
          res_idx_d = scan_res.best;
        end else begin
          res_status_d = STAT_NO_ALIVE;
        end
      end
      REQ_QUERY: begin
        if (idx_ok) begin
          res_idx_d = idx_q;
        end else begin
          res_status_d = STAT_BAD_INDEX;
        end
      end
      default: begin
        // unknown request: ok with empty fields
        res_zero_d = 1'b1;
      end
    endcase
  end

  assign res_tbl = res_idx_q[TblIdxW-1:0];

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      scan_cnt_q  <= '0;
      ports_q     <= '0;
      serv_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      scan_cnt_q <= scan_cnt_d;
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          REG_SERVER_PORTS: ports_q    <= cfg_wdata_i;
          REG_SERVER_COUNT: serv_cnt_q <= cfg_wdata_i[ServCntW-1:0];
          default:          ports_q    <= ports_q;
        endcase
      end
      if ((state_q == S_RESULT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // server table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(MAX_SERVERS); i++) begin
        alive_q[i] <= 1'b0;
        count_q[i] <= '0;
      end
    end else if ((state_q == S_EXEC) && upd_we) begin
      alive_q[upd_tbl] <= upd_alive;
      count_q[upd_tbl] <= upd_count;
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      req_q  <= s_axis_tuser;
      port_q <= s_axis_tdata[15:0];
      idx_q  <= s_axis_tdata[17:16];
      up_q   <= s_axis_tdata[18];
    end
    if (state_q == S_EXEC) begin
      res_status_q <= res_status_d;
      res_zero_q   <= res_zero_d;
      res_idx_q    <= res_idx_d;
    end
    if ((state_q == S_RESULT) && out_free) begin
      out_status_q <= res_status_q;
      if ((res_status_q == STAT_OK) && !res_zero_q) begin
        out_idx_q   <= res_idx_q;
        out_duty_q  <= alive_q[res_tbl];
        out_count_q <= OutCntW'(count_q[res_tbl]);
      end else begin
        out_idx_q   <= '0;
        out_duty_q  <= 1'b0;
        out_count_q <= '0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {5'd0, out_count_q, out_duty_q, out_idx_q};

`ifndef SYNTHESIS
  // a failed request carries empty fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser != STAT_OK)) |-> (m_axis_tdata == '0))
    else $error("non-ok result with non-empty fields");

  // the scan never runs past the servers in use
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (scan_cnt_q < n_use))
    else $error("scan index beyond servers in use");

  // one request at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> !s_axis_tready)
    else $error("request taken while busy");

  // a new result only comes from the final sequencer step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> ($past(state_q) == S_RESULT))
    else $error("result loaded outside the result step");
`endif

endmodule

`default_nettype wire
